/* rtl/core/tournament_tree_top_k_select_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tournament tree top-k selection core.
// Each macro checks a property on the rising edge of clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_TREE_TOP_K_SELECT_CORE_ASSERT_SVH
`define TOURNAMENT_TREE_TOP_K_SELECT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TTKS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttks assertion failed");

// Next-cycle implication.
`define TTKS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttks assertion failed");

`else

`define TTKS_ASSERT_IMP(label, ante, cons)
`define TTKS_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* rtl/core/ttks_pkg.sv */
// ----------------------------------------------------------------------------
// ttks_pkg
// Shared constants for the tournament tree top-k selection core.
// ----------------------------------------------------------------------------
package ttks_pkg;

  // Default sizes.
  localparam int MAX_ITEMS_DEF  = 4096;
  localparam int MAX_K_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Port widths fixed by the interface.
  localparam int ITEM_IN_W  = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int K_REG_W    = 7;

  // Register index of result_count (paddr bit 2 and up).
  localparam logic [0:0] REG_RESULT_COUNT = 1'b0;

  // Group order flag codes.
  localparam logic [1:0] FLAG_COMPARE = 2'd0;
  localparam logic [1:0] FLAG_MIDDLE  = 2'd1;
  localparam logic [1:0] FLAG_LAST    = 2'd2;

  // Slot picked to refill the head of a group.
  localparam logic [1:0] PICK_NONE   = 2'd0;
  localparam logic [1:0] PICK_MIDDLE = 2'd1;
  localparam logic [1:0] PICK_LAST   = 2'd2;

endpackage

/* rtl/core/ttks_ram.sv */
// ----------------------------------------------------------------------------
// ttks_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tournament_tree_top_k_select_core.sv */
// ----------------------------------------------------------------------------
// Tournament tree top-k selection core.
// Loading takes one item per cycle while the core is idle. The final item starts
// a build of the groups of three and the upper tree nodes, paced by the
// single shared value comparator and the one-read-port RAMs. Each report
// then also waits for any output stall.
// Synchronous active-high reset returns to idle with k = 1 and no items.
// ----------------------------------------------------------------------------
`include "tournament_tree_top_k_select_core_assert.svh"

module tournament_tree_top_k_select_core #(
  parameter int MAX_ITEMS  = ttks_pkg::MAX_ITEMS_DEF,
  parameter int MAX_K      = ttks_pkg::MAX_K_DEF,
  parameter int VALUE_BITS = ttks_pkg::VALUE_BITS_DEF,
  localparam int IDXW = $clog2(MAX_ITEMS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ttks_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ttks_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ttks_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ttks_pkg::ITEM_IN_W-1:0]  item_value,
  input  logic                            last_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [IDXW-1:0]                 item_index,
  output logic                            last_result
);
  import ttks_pkg::*;

  localparam int GROUPS     = (MAX_ITEMS + 2) / 3;
  localparam int SLOTS      = 3 * GROUPS;
  localparam int LB_MAX     = 2 ** $clog2(GROUPS);
  localparam int TREE_DEPTH = 2 * LB_MAX;
  localparam int VAW        = $clog2(MAX_ITEMS);
  localparam int SAW        = $clog2(SLOTS);
  localparam int FAW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int NW         = $clog2(TREE_DEPTH);
  localparam int GW         = $clog2(GROUPS + 1);
  localparam int BW         = $clog2(SLOTS + 1);
  localparam int KW         = $clog2(MAX_K + 1);
  localparam int CW         = ((IDXW > K_REG_W) ? IDXW : K_REG_W) + 2;
  localparam int SH         = IDXW + 2;
  localparam int RECIP      = (2 ** SH) / 3;

  // Sequencer states.
  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_LB   = 6'd1;
  localparam logic [5:0] S_G0   = 6'd2;
  localparam logic [5:0] S_G1   = 6'd3;
  localparam logic [5:0] S_G2   = 6'd4;
  localparam logic [5:0] S_G3   = 6'd5;
  localparam logic [5:0] S_G4   = 6'd6;
  localparam logic [5:0] S_G5   = 6'd7;
  localparam logic [5:0] S_PAD  = 6'd8;
  localparam logic [5:0] S_T0   = 6'd9;
  localparam logic [5:0] S_T1   = 6'd10;
  localparam logic [5:0] S_T2   = 6'd11;
  localparam logic [5:0] S_T4   = 6'd12;
  localparam logic [5:0] S_K    = 6'd13;
  localparam logic [5:0] S_E0   = 6'd14;
  localparam logic [5:0] S_E1   = 6'd15;
  localparam logic [5:0] S_E2   = 6'd16;
  localparam logic [5:0] S_R0   = 6'd17;
  localparam logic [5:0] S_R1   = 6'd18;
  localparam logic [5:0] S_R2   = 6'd19;
  localparam logic [5:0] S_R3   = 6'd20;
  localparam logic [5:0] S_R4   = 6'd21;
  localparam logic [5:0] S_R5   = 6'd22;
  localparam logic [5:0] S_R6   = 6'd23;
  localparam logic [5:0] S_R7   = 6'd24;
  localparam logic [5:0] S_R8   = 6'd25;
  localparam logic [5:0] S_R9   = 6'd26;
  localparam logic [5:0] S_R10  = 6'd27;
  localparam logic [5:0] S_C0   = 6'd28;
  localparam logic [5:0] S_C1   = 6'd29;
  localparam logic [5:0] S_C2   = 6'd30;

  logic [5:0]            state;
  logic [5:0]            cret;
  logic [IDXW-1:0]       cnt;
  logic [GW-1:0]         groups;
  logic [1:0]            pos;
  logic [K_REG_W-1:0]    result_count;
  logic [NW-1:0]         lb;
  logic [GW-1:0]         g;
  logic [BW-1:0]         b;
  logic [IDXW-1:0]       sl0, sl1, sl2;
  logic                  x1;
  logic [1:0]            flag;
  logic [NW-1:0]         node;
  logic [IDXW-1:0]       l_item, r_item;
  logic [IDXW-1:0]       ca, cb;
  logic [VALUE_BITS-1:0] va;
  logic                  res;
  logic                  replay;
  logic [KW-1:0]         k;
  logic [KW-1:0]         i;
  logic [IDXW+SH-1:0]    prod;
  logic [IDXW-1:0]       m_item, z_item;
  logic [1:0]            f_code;
  logic [1:0]            pick;

  logic                  in_accept;
  logic                  store_ok;
  logic                  cfg_we;
  logic [NW-1:0]         lb_g;
  logic [IDXW-1:0]       it0, it1, it2;
  logic [IDXW-1:0]       top_m1;
  logic [CW-1:0]         rem;
  logic [IDXW-1:0]       new0;
  logic                  last_group;

  logic                  val_we;
  logic [VAW-1:0]        val_waddr, val_raddr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;
  logic                  slot_we;
  logic [SAW-1:0]        slot_waddr, slot_raddr;
  logic [IDXW-1:0]       slot_wdata, slot_rdata;
  logic                  flag_we;
  logic [1:0]            flag_rdata;
  logic                  tree_we;
  logic [NW-1:0]         tree_waddr, tree_raddr;
  logic [IDXW-1:0]       tree_wdata, tree_rdata;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_RESULT_COUNT)
                  ? CFG_DATA_W'(result_count) : '0;

  // Handshake and helper values.
  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid & ~in_stall;
  assign store_ok   = CW'(cnt) < CW'(MAX_ITEMS);
  assign lb_g       = NW'(CW'(lb) + CW'(g));
  assign it0 = (CW'(b) < CW'(cnt)) ? IDXW'(CW'(b) + CW'(1)) : '0;
  assign it1 = (CW'(b) + CW'(1) < CW'(cnt)) ? IDXW'(CW'(b) + CW'(2)) : '0;
  assign it2 = (CW'(b) + CW'(2) < CW'(cnt)) ? IDXW'(CW'(b) + CW'(3)) : '0;
  assign top_m1     = item_index - 1'b1;
  assign rem        = CW'(top_m1) - ((CW'(g) << 1) + CW'(g));
  assign last_group = (CW'(g) + CW'(1) == CW'(groups));

  always_comb begin
    case (pick)
      PICK_MIDDLE: new0 = m_item;
      PICK_LAST:   new0 = z_item;
      default:     new0 = '0;
    endcase
  end

  // Value store: written while loading, read by the comparator.
  assign val_we    = in_accept & store_ok;
  assign val_waddr = VAW'(cnt);
  assign val_wdata = VALUE_BITS'(item_value);
  assign val_raddr = (state == S_C1) ? VAW'(cb - 1'b1) : VAW'(ca - 1'b1);

  // Slot store ports.
  assign slot_raddr = (state == S_R5) ? SAW'(CW'(b) + CW'(2)) : SAW'(CW'(b) + CW'(1));
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = SAW'(b);
    slot_wdata = '0;
    case (state)
      S_G3: begin
        slot_we    = 1'b1;
        slot_wdata = sl0;
      end
      S_G4: begin
        slot_we    = 1'b1;
        slot_waddr = SAW'(CW'(b) + CW'(1));
        slot_wdata = sl1;
      end
      S_G5: begin
        slot_we    = 1'b1;
        slot_waddr = SAW'(CW'(b) + CW'(2));
        slot_wdata = sl2;
      end
      S_R9: begin
        slot_we    = 1'b1;
        slot_wdata = new0;
      end
      S_R10: begin
        slot_we    = (pick != PICK_NONE);
        slot_waddr = SAW'(CW'(b) + CW'(pick));
      end
      default: begin
        slot_we = 1'b0;
      end
    endcase
  end

  // Group order flags are written once per group during the build.
  assign flag_we = (state == S_G3);

  // Tree node store ports.
  always_comb begin
    case (state)
      S_T0:    tree_raddr = NW'(CW'(node) << 1);
      S_T1:    tree_raddr = NW'((CW'(node) << 1) + CW'(1));
      default: tree_raddr = NW'(1);
    endcase
  end

  always_comb begin
    tree_we    = 1'b0;
    tree_waddr = lb_g;
    tree_wdata = '0;
    case (state)
      S_G3: begin
        tree_we    = 1'b1;
        tree_wdata = sl0;
      end
      S_PAD: begin
        tree_we    = 1'b1;
        tree_waddr = node;
      end
      S_T4: begin
        tree_we    = 1'b1;
        tree_waddr = node;
        tree_wdata = res ? r_item : l_item;
      end
      S_R9: begin
        tree_we    = 1'b1;
        tree_wdata = new0;
      end
      default: begin
        tree_we = 1'b0;
      end
    endcase
  end

  ttks_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_value_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(val_raddr), .rdata(val_rdata)
  );

  ttks_ram #(.WIDTH(IDXW), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  ttks_ram #(.WIDTH(2), .DEPTH(GROUPS)) u_flag_ram (
    .clk(clk), .we(flag_we), .waddr(FAW'(g)), .wdata(flag),
    .raddr(FAW'(g)), .rdata(flag_rdata)
  );

  ttks_ram #(.WIDTH(IDXW), .DEPTH(TREE_DEPTH)) u_tree_ram (
    .clk(clk), .we(tree_we), .waddr(tree_waddr), .wdata(tree_wdata),
    .raddr(tree_raddr), .rdata(tree_rdata)
  );

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      cnt          <= '0;
      groups       <= '0;
      pos          <= '0;
      result_count <= K_REG_W'(1);
    end else begin
      if (cfg_we && paddr[CFG_ADDR_W-1:2] == REG_RESULT_COUNT) begin
        result_count <= pwdata[K_REG_W-1:0];
      end
      case (state)
        // Load one item per transfer.
        S_IDLE: begin
          if (in_accept) begin
            if (store_ok) begin
              cnt <= cnt + 1'b1;
              if (pos == 2'd0) begin
                groups <= groups + 1'b1;
              end
              pos <= (pos == 2'd2) ? 2'd0 : pos + 2'd1;
            end
            if (last_item) begin
              lb    <= NW'(1);
              state <= S_LB;
            end
          end
        end
        // Leaf base is the smallest power of two that covers the groups.
        S_LB: begin
          if (CW'(lb) < CW'(groups)) begin
            lb <= NW'(CW'(lb) << 1);
          end else begin
            g     <= '0;
            b     <= '0;
            state <= S_G0;
          end
        end
        // Build one group: order its three slots.
        S_G0: begin
          sl0   <= it0;
          sl1   <= it1;
          sl2   <= it2;
          ca    <= it1;
          cb    <= it0;
          cret  <= S_G1;
          state <= S_C0;
        end
        S_G1: begin
          x1    <= res;
          ca    <= sl2;
          cb    <= res ? sl1 : sl0;
          cret  <= S_G2;
          state <= S_C0;
        end
        S_G2: begin
          if (x1 && res) begin
            flag <= FLAG_MIDDLE;
          end else if (!x1 && res) begin
            flag <= FLAG_LAST;
          end else begin
            flag <= FLAG_COMPARE;
          end
          if (res) begin
            sl0 <= sl2;
            sl2 <= sl0;
          end else if (x1) begin
            sl0 <= sl1;
            sl1 <= sl0;
          end
          state <= S_G3;
        end
        S_G3: begin
          state <= S_G4;
        end
        S_G4: begin
          state <= S_G5;
        end
        S_G5: begin
          g <= g + 1'b1;
          b <= BW'(CW'(b) + CW'(3));
          if (!last_group) begin
            state <= S_G0;
          end else if (CW'(groups) != CW'(lb)) begin
            node  <= NW'(CW'(lb) + CW'(groups));
            state <= S_PAD;
          end else begin
            replay <= 1'b0;
            node   <= lb - 1'b1;
            state  <= (lb == NW'(1)) ? S_K : S_T0;
          end
        end
        // Unused leaves hold the empty item.
        S_PAD: begin
          if (CW'(node) + CW'(1) == (CW'(lb) << 1)) begin
            replay <= 1'b0;
            node   <= lb - 1'b1;
            state  <= (lb == NW'(1)) ? S_K : S_T0;
          end else begin
            node <= node + 1'b1;
          end
        end
        // One upper node: read both children and keep the winner.
        S_T0: begin
          state <= S_T1;
        end
        S_T1: begin
          l_item <= tree_rdata;
          state  <= S_T2;
        end
        S_T2: begin
          r_item <= tree_rdata;
          ca     <= tree_rdata;
          cb     <= l_item;
          cret   <= S_T4;
          state  <= S_C0;
        end
        S_T4: begin
          if (node == NW'(1)) begin
            state <= replay ? S_E0 : S_K;
          end else begin
            node  <= replay ? (node >> 1) : (node - 1'b1);
            state <= S_T0;
          end
        end
        // Clamp k to 1..MAX_K and to the item count.
        S_K: begin
          if (result_count == '0) begin
            k <= KW'(1);
          end else if (CW'(result_count) > CW'(cnt) && CW'(cnt) < CW'(MAX_K)) begin
            k <= KW'(cnt);
          end else if (CW'(result_count) > CW'(MAX_K)) begin
            k <= KW'(MAX_K);
          end else begin
            k <= KW'(result_count);
          end
          i     <= '0;
          state <= S_E0;
        end
        // Report the root.
        S_E0: begin
          state <= S_E1;
        end
        S_E1: begin
          item_index  <= tree_rdata;
          last_result <= (CW'(i) + CW'(1) == CW'(k));
          out_valid   <= 1'b1;
          state       <= S_E2;
        end
        S_E2: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_result) begin
              cnt    <= '0;
              groups <= '0;
              pos    <= '0;
              state  <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= (item_index == '0) ? S_E0 : S_R0;
            end
          end
        end
        // Remove the reported item: find its group by a reciprocal multiply.
        S_R0: begin
          prod  <= (IDXW + SH)'(top_m1) * (IDXW + SH)'(RECIP);
          state <= S_R1;
        end
        S_R1: begin
          g     <= GW'(prod >> SH);
          state <= S_R2;
        end
        S_R2: begin
          if (rem >= CW'(3)) begin
            g <= g + 1'b1;
          end
          state <= S_R3;
        end
        S_R3: begin
          b     <= BW'((CW'(g) << 1) + CW'(g));
          state <= S_R4;
        end
        S_R4: begin
          state <= S_R5;
        end
        S_R5: begin
          m_item <= slot_rdata;
          f_code <= flag_rdata;
          state  <= S_R6;
        end
        S_R6: begin
          z_item <= slot_rdata;
          state  <= S_R7;
        end
        S_R7: begin
          if (m_item != '0 && z_item != '0) begin
            case (f_code)
              FLAG_MIDDLE: begin
                pick  <= PICK_MIDDLE;
                state <= S_R9;
              end
              FLAG_LAST: begin
                pick  <= PICK_LAST;
                state <= S_R9;
              end
              default: begin
                ca    <= z_item;
                cb    <= m_item;
                cret  <= S_R8;
                state <= S_C0;
              end
            endcase
          end else begin
            if (m_item != '0) begin
              pick <= PICK_MIDDLE;
            end else if (z_item != '0) begin
              pick <= PICK_LAST;
            end else begin
              pick <= PICK_NONE;
            end
            state <= S_R9;
          end
        end
        S_R8: begin
          pick  <= res ? PICK_LAST : PICK_MIDDLE;
          state <= S_R9;
        end
        S_R9: begin
          state <= S_R10;
        end
        S_R10: begin
          if (lb_g == NW'(1)) begin
            state <= S_E0;
          end else begin
            replay <= 1'b1;
            node   <= lb_g >> 1;
            state  <= S_T0;
          end
        end
        // Shared comparator: does item ca rank above item cb?
        S_C0: begin
          if (ca == '0) begin
            res   <= 1'b0;
            state <= cret;
          end else if (cb == '0) begin
            res   <= 1'b1;
            state <= cret;
          end else begin
            state <= S_C1;
          end
        end
        S_C1: begin
          va    <= val_rdata;
          state <= S_C2;
        end
        S_C2: begin
          res   <= (va > val_rdata) || ((va == val_rdata) && (ca < cb));
          state <= cret;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer.
  `TTKS_ASSERT_IMP(a_busy_while_reporting, out_valid, in_stall)
  `TTKS_ASSERT_IMP(a_report_not_empty, out_valid, item_index != '0)
  `TTKS_ASSERT_NXT(a_last_starts_build, in_valid && !in_stall && last_item, in_stall)
  `TTKS_ASSERT_IMP(a_group_quotient, state == S_R3, rem < CW'(3))

endmodule

/* verif/tournament_tree_top_k_select_core_test.sv */
// ----------------------------------------------------------------------------
// Tournament tree top-k selection core test
// Streams item sets through the core under random flow control and checks
// every reported index against an in-bench model that ranks the stored set.
// ----------------------------------------------------------------------------
module tournament_tree_top_k_select_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ttks_pkg::*;

  localparam int MAX_ITEMS = MAX_ITEMS_DEF;
  localparam int MAX_K = MAX_K_DEF;
  localparam int IDXW = $clog2(MAX_ITEMS + 1);
  localparam int IDLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [IDXW-1:0] index;
    logic            last;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ITEM_IN_W-1:0] item_value = '0;
  logic last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDXW-1:0] item_index;
  logic last_result;

  // Model state: the stored set and the programmed k.
  logic [31:0] set_values[$];
  int k_setting = 1;
  pick_t expected_picks[$];
  int error_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  tournament_tree_top_k_select_core i_dut (.*);

  // Clock with period 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // Ranks the stored set and queues the k best indices, largest value first.
  task automatic rank_stored_set();
    int n, k, best;
    bit taken[];
    n = set_values.size();
    k = k_setting;
    if (k < 1) k = 1;
    if (k > MAX_K) k = MAX_K;
    if (k > n) k = n;
    taken = new[n];
    for (int i = 0; i < k; i++) begin
      best = -1;
      for (int j = 0; j < n; j++) begin
        if (!taken[j] && (best < 0 || set_values[j] > set_values[best])) best = j;
      end
      taken[best] = 1'b1;
      expected_picks.push_back('{index: IDXW'(best + 1), last: (i + 1 == k)});
    end
    set_values.delete();
  endtask

  // Sends one item transfer and updates the model once it is accepted.
  // Valid stays high on return so that items can follow back to back.
  task automatic send_item(input logic [31:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    item_value <= value;
    last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (set_values.size() < MAX_ITEMS) set_values.push_back(value);
    if (last) rank_stored_set();
    @(negedge clk);
  endtask

  task automatic write_k(input int value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({REG_RESULT_COUNT, 2'b00});
    pwdata <= CFG_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    k_setting = value & 32'h7f;
  endtask

  // Ends the item stream and waits until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_picks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_set(input int n, input int mode);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = $urandom();
        1: v = $urandom_range(3);
        default: v = ($urandom_range(1)) ? 32'hffff_ffff : 32'h0;
      endcase
      send_item(v, i == n - 1);
    end
  endtask

  // Extremes of value, ties, short groups and out-of-range k.
  task automatic test_directed();
    write_k(3);
    send_item(32'h0, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h5555_5555, 1'b1);
    wait_drained();
    write_k(0);
    send_item(32'haaaa_aaaa, 1'b1);
    wait_drained();
    write_k(127);
    send_set(5, 1);
    wait_drained();
    write_k(64);
    send_set(7, 2);
    wait_drained();
  endtask

  // Random sets of small size under each setting of k.
  task automatic test_random_sets(input int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(3))
        0: write_k(1);
        1: write_k(MAX_K);
        2: write_k($urandom_range(127));
        default: write_k($urandom_range(1, 10));
      endcase
      n = $urandom_range(1, 20);
      send_set(n, $urandom_range(2));
      sent += n;
      wait_drained();
    end
  endtask

  // Result checker and receiver stall.
  always @(posedge clk) begin
    pick_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected index %0d", item_index));
      end else begin
        want = expected_picks.pop_front();
        if (item_index !== want.index)
          report_mismatch($sformatf("index %0d, want %0d", item_index, want.index));
        if (last_result !== want.last)
          report_mismatch($sformatf("last flag %b, want %b", last_result, want.last));
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Watchdog on cycles with no transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 82;
    test_directed();
    test_random_sets(100);
    send_idle_pct = 82;
    recv_idle_pct = 16;
    test_random_sets(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sets(100);
    wait_drained();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ttks_pkg.sv
rtl/core/ttks_ram.sv
rtl/core/tournament_tree_top_k_select_core.sv
verif/tournament_tree_top_k_select_core_test.sv
